@@ sv/pls_pkg.sv @@
// Shared types, codes and sizes for the positional list store.
package pls_pkg;

  // Number of cells in the row.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the channels.
  localparam int unsigned REQ_TYPE_W = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ECOUNT_W   = 5;

  // Request codes.
  localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_INSERT     = 3'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_ERASE      = 3'd3;
  localparam logic [REQ_TYPE_W-1:0] REQ_READ       = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_CLAMP = 2'd3;

  // Operation broadcast to every cell of the row.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [IDX_W-1:0]    at;
    logic [VALUE_W-1:0]  value;
  } cell_cmd_t;

endpackage

@@ sv/pls_if.sv @@
// Request and response channel interfaces of the positional list store.
interface pls_req_if;
  logic                                valid;
  logic                                ready;
  logic [pls_pkg::REQ_TYPE_W-1:0]      req_type;
  logic signed [pls_pkg::VALUE_W-1:0]  new_value;
  logic [pls_pkg::POS_W-1:0]           position;

  modport source (output valid, req_type, new_value, position, input ready);
  modport sink   (input valid, req_type, new_value, position, output ready);
endinterface

interface pls_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [pls_pkg::STATUS_W-1:0]        status;
  logic [pls_pkg::ECOUNT_W-1:0]        element_count;
  logic signed [pls_pkg::VALUE_W-1:0]  out_value;

  modport source (output valid, status, element_count, out_value, input ready);
  modport sink   (input valid, status, element_count, out_value, output ready);
endinterface

@@ sv/pls_cell.sv @@
// One storage cell of the list row: shifts with its neighbours and taps the read chain.
module pls_cell (
  input  logic                             clk_i,
  input  logic [pls_pkg::IDX_W-1:0]        cell_idx_i,
  input  pls_pkg::cell_cmd_t               cmd_i,
  input  logic [pls_pkg::VALUE_W-1:0]      left_i,
  input  logic [pls_pkg::VALUE_W-1:0]      right_i,
  input  logic [pls_pkg::VALUE_W-1:0]      tap_i,
  output logic [pls_pkg::VALUE_W-1:0]      data_o,
  output logic [pls_pkg::VALUE_W-1:0]      tap_o
);
  import pls_pkg::*;

  logic [VALUE_W-1:0] data_q, data_d;

  // Next value: take the left neighbour on an insert below us, the right one on a delete.
  always_comb begin
    data_d = data_q;
    unique case (cmd_i.op)
      CELL_INSERT: begin
        if (cell_idx_i > cmd_i.at) begin
          data_d = left_i;
        end else if (cell_idx_i == cmd_i.at) begin
          data_d = cmd_i.value;
        end
      end
      CELL_DELETE: begin
        if (cell_idx_i >= cmd_i.at) begin
          data_d = right_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // The addressed cell places its current value onto the read chain.
  assign tap_o  = (cell_idx_i == cmd_i.at) ? (tap_i | data_q) : tap_i;
  assign data_o = data_q;

endmodule

@@ sv/pls_row.sv @@
// Row of storage cells with neighbour links and the read chain.
module pls_row (
  input  logic                          clk_i,
  input  pls_pkg::cell_cmd_t            cmd_i,
  output logic [pls_pkg::VALUE_W-1:0]   tap_o
);
  import pls_pkg::*;

  logic [VALUE_W-1:0] data  [CAPACITY];
  logic [VALUE_W-1:0] chain [CAPACITY+1];

  assign chain[0] = '0;

  // Each cell sees its neighbours; the ends see zero.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = data[i+1];
    end

    pls_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(i)),
      .cmd_i      (cmd_i),
      .left_i     (left),
      .right_i    (right),
      .tap_i      (chain[i]),
      .data_o     (data[i]),
      .tap_o      (chain[i+1])
    );
  end

  assign tap_o = chain[CAPACITY];

endmodule

@@ sv/positional_list_store_core.sv @@
// Top level of the positional list store: request decode, cell row and response register.
//
//   Channel  Direction  Contents
//   req_i    in         req_type, new_value, position
//   rsp_o    out        status, element_count, out_value
//
// Every request is decoded and applied to the whole cell row in the cycle it
// is transferred, so one request is taken per clock cycle unless the response stalls.
// The response appears in the cycle after the transfer and sits in a register.
// A new request is taken while the response register is empty or being read.
// Reset empties the list and the response register; stored values are not cleared.
module positional_list_store_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  pls_req_if.sink   req_i,
  pls_rsp_if.source rsp_o
);
  import pls_pkg::*;

  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]    count_q, count_d;
  logic                rsp_valid_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [ECOUNT_W-1:0] ecount_q;
  logic [VALUE_W-1:0]  value_q, value_d;
  logic [CMP_W-1:0]    pos_ext, cnt_ext, cnt_d_ext;
  logic                accept, rd_req;
  cell_cmd_t           cmd;
  logic [VALUE_W-1:0]  tap;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign pos_ext   = CMP_W'(req_i.position);
  assign cnt_ext   = CMP_W'(count_q);
  assign cnt_d_ext = CMP_W'(count_d);

  // Decode the request into one row operation, a status and the new count.
  always_comb begin
    cmd.op    = CELL_HOLD;
    cmd.at    = '0;
    cmd.value = req_i.new_value;
    status_d  = STATUS_OK;
    count_d   = count_q;
    rd_req    = 1'b0;
    unique case (req_i.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
        if (cnt_ext == CMP_W'(CAPACITY)) begin
          status_d = STATUS_FULL;
        end else begin
          cmd.op  = CELL_INSERT;
          count_d = count_q + 1'b1;
          if (req_i.req_type == REQ_PUSH_FRONT) begin
            cmd.at = '0;
          end else if (req_i.req_type == REQ_PUSH_BACK) begin
            cmd.at = IDX_W'(count_q);
          end else if (pos_ext > cnt_ext) begin
            cmd.at   = IDX_W'(count_q);
            status_d = STATUS_CLAMP;
          end else begin
            cmd.at = IDX_W'(req_i.position);
          end
        end
      end
      REQ_ERASE, REQ_READ: begin
        if (count_q == '0) begin
          status_d = STATUS_EMPTY;
        end else begin
          rd_req = 1'b1;
          if (pos_ext >= cnt_ext) begin
            cmd.at   = IDX_W'(count_q - 1'b1);
            status_d = STATUS_CLAMP;
          end else begin
            cmd.at = IDX_W'(req_i.position);
          end
          if (req_i.req_type == REQ_ERASE) begin
            cmd.op  = CELL_DELETE;
            count_d = count_q - 1'b1;
          end
        end
      end
      default: begin
        status_d = STATUS_OK;
      end
    endcase
    if (!accept) begin
      cmd.op = CELL_HOLD;
    end
  end

  // Value read out of the addressed cell before the row moves.
  assign value_d = rd_req ? tap : '0;

  pls_row u_row (
    .clk_i (clk_i),
    .cmd_i (cmd),
    .tap_o (tap)
  );

  // List length and response valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Response payload, loaded on every request transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      ecount_q <= cnt_d_ext[ECOUNT_W-1:0];
      value_q  <= value_d;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.element_count = ecount_q;
  assign rsp_o.out_value     = value_q;

endmodule

@@ sv/pls_checker.sv @@
// Port-level checks of the positional list store and their binding to the top level.
module pls_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rsp_valid_i,
  input  logic                            rsp_ready_i,
  input  logic [pls_pkg::STATUS_W-1:0]    rsp_status_i,
  input  logic [pls_pkg::ECOUNT_W-1:0]    rsp_count_i,
  input  logic [pls_pkg::VALUE_W-1:0]     rsp_value_i
);
  import pls_pkg::*;

  // A stalled response keeps its payload.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_count_i) && $stable(rsp_value_i))
    else $error("response changed while stalled");

  // A dropped insert is only reported when the list is at capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == STATUS_FULL |->
      rsp_count_i == ECOUNT_W'(CAPACITY))
    else $error("full status with a list below capacity");

  // An empty answer leaves the list empty and returns no value.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == STATUS_EMPTY |->
      rsp_count_i == '0 && rsp_value_i == '0)
    else $error("empty status with elements or a value");

  // The reported length never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_count_i <= ECOUNT_W'(CAPACITY))
    else $error("element count beyond capacity");

endmodule

bind positional_list_store_core pls_checker u_pls_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_count_i  (rsp_o.element_count),
  .rsp_value_i  (rsp_o.out_value)
);

@@ sim/tb.sv @@
// Self-checking testbench for the positional list store core.
module tb;
  import pls_pkg::*;

  // First of the request codes that the block leaves unused.
  localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_FIRST = 3'd5;
  // Cycles the response side holds off during the back-pressure test.
  localparam int unsigned RSP_HOLD_CYCLES = 100;
  // Cycles without any transfer after which the run is abandoned.
  localparam int unsigned STALL_LIMIT = 1000;

  typedef struct {
    logic [STATUS_W-1:0]        status;
    logic [ECOUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0]  value;
  } list_response_t;

  logic clk;
  logic rst_n;

  pls_req_if req_bus ();
  pls_rsp_if rsp_bus ();

  positional_list_store_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Predicted contents of the list.
  logic signed [VALUE_W-1:0] list_cells [CAPACITY];
  int unsigned               list_len;

  list_response_t pending_responses [$];
  list_response_t due_response;
  int unsigned    fault_count;
  int unsigned    idle_cycles;
  int unsigned    stall_left;
  bit             idle_en;
  bit             hold_rsp;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one request to the predicted list and returns the response it should give.
  function automatic list_response_t list_apply(logic [REQ_TYPE_W-1:0] kind,
                                                logic signed [VALUE_W-1:0] value,
                                                logic [POS_W-1:0] pos);
    list_response_t r;
    int unsigned    at;
    int unsigned    i;
    r.status = STATUS_OK;
    r.value  = '0;
    at       = pos;
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          if (kind == REQ_PUSH_FRONT) begin
            at = 0;
          end else if (kind == REQ_PUSH_BACK) begin
            at = list_len;
          end else if (at > list_len) begin
            at       = list_len;
            r.status = STATUS_CLAMP;
          end
          for (i = list_len; i > at; i--) list_cells[i] = list_cells[i-1];
          list_cells[at] = value;
          list_len++;
        end
      end
      REQ_ERASE, REQ_READ: begin
        if (list_len == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          if (at >= list_len) begin
            at       = list_len - 1;
            r.status = STATUS_CLAMP;
          end
          r.value = list_cells[at];
          if (kind == REQ_ERASE) begin
            for (i = at; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
            list_len--;
          end
        end
      end
      default: begin
      end
    endcase
    r.count = ECOUNT_W'(list_len);
    return r;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_en) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 10);
  endfunction

  // Stored value, with the extremes of the range mixed in.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return $signed({1'b1, {(VALUE_W-1){1'b0}}});
      1:       return $signed({1'b0, {(VALUE_W-1){1'b1}}});
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random request; growing favours additions, otherwise erases dominate.
  function automatic void pick_request(input bit growing,
                                       output logic [REQ_TYPE_W-1:0] kind,
                                       output logic signed [VALUE_W-1:0] value,
                                       output logic [POS_W-1:0] pos);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) begin
      kind = REQ_SPARE_FIRST + REQ_TYPE_W'($urandom_range(2));
    end else if (roll < (growing ? 70 : 25)) begin
      case ($urandom_range(2))
        0:       kind = REQ_PUSH_FRONT;
        1:       kind = REQ_PUSH_BACK;
        default: kind = REQ_INSERT;
      endcase
    end else begin
      kind = ($urandom_range(2) != 0) ? REQ_ERASE : REQ_READ;
    end
    value = pick_value();
    // Positions mostly fall within the list or just past its end.
    if ($urandom_range(3) == 0) pos = POS_W'($urandom_range(255));
    else                        pos = POS_W'($urandom_range(list_len));
  endfunction

  // Offers one request and records its expected response once it is transferred.
  task automatic send_item(logic [REQ_TYPE_W-1:0] kind, logic signed [VALUE_W-1:0] value,
                           logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      req_bus.valid <= 1'b0;
    end
    @(negedge clk);
    req_bus.valid     <= 1'b1;
    req_bus.req_type  <= kind;
    req_bus.new_value <= value;
    req_bus.position  <= pos;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    pending_responses.insert(pending_responses.size(), list_apply(kind, value, pos));
  endtask

  // Stops offering requests until every outstanding response has arrived.
  task automatic wait_all_answered();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  // Erase, read and unused codes on an empty list.
  task automatic test_empty_list();
    send_item(REQ_ERASE, '0, '0);
    send_item(REQ_READ, '1, '1);
    send_item(REQ_SPARE_FIRST, pick_value(), POS_W'(3));
    send_item(REQ_SPARE_FIRST + REQ_TYPE_W'(2), '1, '1);
  endtask

  // Both ends, insert at the front, at the end and past it, clamped erase and read.
  task automatic test_list_ends();
    send_item(REQ_PUSH_FRONT, $signed({1'b1, {(VALUE_W-1){1'b0}}}), POS_W'(9));
    send_item(REQ_PUSH_BACK, $signed({1'b0, {(VALUE_W-1){1'b1}}}), '0);
    send_item(REQ_INSERT, '1, '0);
    send_item(REQ_INSERT, 32'sd1, POS_W'(list_len));
    send_item(REQ_INSERT, 32'sh5555_5555, '1);
    send_item(REQ_READ, '0, '1);
    send_item(REQ_ERASE, '0, POS_W'(200));
    send_item(REQ_ERASE, '0, '0);
    send_item(REQ_READ, '0, '0);
  endtask

  // Fill the list, then check that additions are dropped and the last cell is reachable.
  task automatic test_full_list();
    logic [REQ_TYPE_W-1:0] kind;
    while (list_len < CAPACITY) begin
      case (list_len % 3)
        0:       kind = REQ_PUSH_FRONT;
        1:       kind = REQ_INSERT;
        default: kind = REQ_PUSH_BACK;
      endcase
      send_item(kind, pick_value(), POS_W'(list_len / 2));
    end
    send_item(REQ_PUSH_FRONT, pick_value(), '0);
    send_item(REQ_PUSH_BACK, pick_value(), '0);
    send_item(REQ_INSERT, pick_value(), POS_W'(CAPACITY / 2));
    send_item(REQ_READ, '0, POS_W'(CAPACITY - 1));
    send_item(REQ_ERASE, '0, POS_W'(CAPACITY - 1));
  endtask

  // Response side holds off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    logic [REQ_TYPE_W-1:0]     kind;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
    int unsigned               k;
    idle_en  = 1'b0;
    hold_rsp = 1'b1;
    for (k = 0; k < 24; k++) begin
      pick_request(list_len < CAPACITY / 2, kind, value, pos);
      send_item(kind, value, pos);
    end
    wait_all_answered();
    idle_en = 1'b1;
  endtask

  // Random traffic that swings the list between empty and full.
  task automatic test_random_mix(int unsigned n_items);
    logic [REQ_TYPE_W-1:0]     kind;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
    int unsigned               k;
    bit                        growing;
    growing = 1'b1;
    for (k = 0; k < n_items; k++) begin
      // Some stretches run without any idling on either side.
      if (k % 40 == 0) idle_en = ($urandom_range(3) != 0);
      // The sender pauses now and then until the block has answered everything.
      if (k % 100 == 99) wait_all_answered();
      if (list_len >= CAPACITY)      growing = 1'b0;
      else if (list_len == 0)        growing = 1'b1;
      else if ($urandom_range(19) == 0) growing = !growing;
      pick_request(growing, kind, value, pos);
      send_item(kind, value, pos);
    end
    idle_en = 1'b1;
  endtask

  // Response side: random stalls, plus one long hold-off on request.
  initial begin : response_sink
    rsp_bus.ready = 1'b0;
    stall_left    = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_bus.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
        rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_bus.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Compare each transferred response with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_responses.size() == 0) begin
        $error("response transfer with no request outstanding");
        fault_count++;
      end else begin
        due_response = pending_responses.pop_front();
        if (rsp_bus.status !== due_response.status) begin
          $error("status: expected %0d, got %0d", due_response.status, rsp_bus.status);
          fault_count++;
        end
        if (rsp_bus.element_count !== due_response.count) begin
          $error("element_count: expected %0d, got %0d", due_response.count,
                 rsp_bus.element_count);
          fault_count++;
        end
        if (rsp_bus.out_value !== due_response.value) begin
          $error("out_value: expected %0d, got %0d", due_response.value, rsp_bus.out_value);
          fault_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel makes a transfer.
  always @(posedge clk) begin
    if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("positional_list_store_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin : stimulus
    rst_n             = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.req_type  = REQ_PUSH_FRONT;
    req_bus.new_value = '0;
    req_bus.position  = '0;
    list_len          = 0;
    fault_count       = 0;
    idle_cycles       = 0;
    idle_en           = 1'b1;
    hold_rsp          = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_list_ends();
    test_full_list();
    test_backpressure();
    test_random_mix(340);

    wait_all_answered();
    repeat (4) @(posedge clk);
    if (fault_count == 0) begin
      $display("positional_list_store_core regression: pass");
    end else begin
      $display("positional_list_store_core regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pls_pkg.sv
sv/pls_if.sv
sv/pls_cell.sv
sv/pls_row.sv
sv/positional_list_store_core.sv
sv/pls_checker.sv
sim/tb.sv
